/* sv/trlp_pkg.sv */
`default_nettype none

package trlp_pkg;

  // Line kinds as reported on the result channel
  localparam logic [2:0] KIND_V    = 3'd0;
  localparam logic [2:0] KIND_T    = 3'd1;
  localparam logic [2:0] KIND_P    = 3'd2;
  localparam logic [2:0] KIND_BA   = 3'd3;
  localparam logic [2:0] KIND_A    = 3'd4;
  localparam logic [2:0] KIND_DI   = 3'd5;
  localparam logic [2:0] KIND_ECHO = 3'd6;

  // ASCII codes the parser reacts to
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_V     = 8'h56;

  // Battery average: Q8 tenths of a volt, avg = (19*avg + v*2^F) / 20
  localparam int AVG_W     = 24;
  localparam int AVG_FRAC  = 8;
  localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};
  // Any input at or above this cap saturates the average anyway
  localparam int UV_CAP    = ((20 * (1 << AVG_W)) + (1 << AVG_FRAC) - 1) >> AVG_FRAC;
  localparam int UV_CAP_W  = $clog2(UV_CAP + 1);
  // 19*avg plus capped scaled input stays below 2^30
  localparam int SUM_W     = 30;
  // Divide by 20 as shift by two then multiply by ceil(2^30 / 5)
  localparam int DIV_X_W   = SUM_W - 2;
  localparam int RECIP_SH  = 30;
  localparam int RECIP_W   = 28;
  localparam logic [RECIP_W-1:0] RECIP_5 = 28'd214748365;
  localparam int PROD_W    = DIV_X_W + RECIP_W;
  localparam int QUO_W     = PROD_W - RECIP_SH;

  // Control part of one finished line
  typedef struct packed {
    logic [2:0] kind;
    logic       perr;
    logic       stop;
    logic       upd;
  } line_ctl_t;

endpackage

`default_nettype wire

/* sv/trlp_parse.sv */
`default_nettype none

module trlp_parse #(
  parameter int VALUE_BITS = 21
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         go,
  input  wire logic [7:0]                   rx_byte,
  output logic                              res_vld,
  output trlp_pkg::line_ctl_t               res_ctl,
  output logic signed [VALUE_BITS-1:0]      res_v0,
  output logic signed [VALUE_BITS-1:0]      res_v1,
  output logic signed [VALUE_BITS-1:0]      res_v2
);

  localparam int EW = VALUE_BITS + 5;
  localparam logic signed [EW-1:0] VMAX_E = EW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] VMIN_E = EW'(-(64'sd1 <<< (VALUE_BITS - 1)));

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_PREFIX = 4'b0010,
    PH_FIELDS = 4'b0100,
    PH_SKIP   = 4'b1000
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [2:0]                    kind_r, kind_nxt;
  logic                          ppos_r, ppos_nxt;
  logic                          pbad_r, pbad_nxt;
  logic [1:0]                    fnum_r, fnum_nxt;
  logic                          neg_r, neg_nxt;
  logic                          started_r, started_nxt;
  logic                          digit_r, digit_nxt;
  logic                          stop_r, stop_nxt;
  logic signed [VALUE_BITS-1:0]  fval_r [3];
  logic signed [VALUE_BITS-1:0]  fval_nxt [3];

  logic signed [VALUE_BITS-1:0]  cur;
  logic signed [EW-1:0]          ext, times10, dig, cand;
  logic signed [VALUE_BITS-1:0]  sat;
  logic                          is_digit, is_sign, is_blank, more_fields, perr_f;
  logic [7:0]                    exp_ch;

  // Digit accumulation for the field in progress
  always_comb begin
    cur      = fval_r[fnum_r];
    ext      = EW'(cur);
    times10  = (ext <<< 3) + (ext <<< 1);
    dig      = EW'({1'b0, rx_byte[3:0]});
    cand     = neg_r ? (times10 - dig) : (times10 + dig);
    if (cand > VMAX_E) begin
      sat = VMAX_E[VALUE_BITS-1:0];
    end else if (cand < VMIN_E) begin
      sat = VMIN_E[VALUE_BITS-1:0];
    end else begin
      sat = cand[VALUE_BITS-1:0];
    end
  end

  // Byte classes
  assign is_digit = (rx_byte >= trlp_pkg::CH_ZERO) && (rx_byte <= trlp_pkg::CH_NINE);
  assign is_sign  = (rx_byte == trlp_pkg::CH_PLUS) || (rx_byte == trlp_pkg::CH_MINUS);
  assign is_blank = (rx_byte == trlp_pkg::CH_SPACE) || (rx_byte == trlp_pkg::CH_TAB) ||
                    (rx_byte == trlp_pkg::CH_LF) || (rx_byte == trlp_pkg::CH_VT) ||
                    (rx_byte == trlp_pkg::CH_FF);
  assign more_fields = ((kind_r == trlp_pkg::KIND_V) && (fnum_r < 2'd2)) ||
                       ((kind_r == trlp_pkg::KIND_T) && (fnum_r < 2'd1));
  assign perr_f = pbad_r || (phase_r == PH_PREFIX);

  always_comb begin
    if (!ppos_r && (kind_r == trlp_pkg::KIND_BA)) begin
      exp_ch = trlp_pkg::CH_A;
    end else if (!ppos_r && (kind_r == trlp_pkg::KIND_DI)) begin
      exp_ch = trlp_pkg::CH_I;
    end else begin
      exp_ch = trlp_pkg::CH_EQ;
    end
  end

  // Line state machine
  always_comb begin
    phase_nxt   = phase_r;
    kind_nxt    = kind_r;
    ppos_nxt    = ppos_r;
    pbad_nxt    = pbad_r;
    fnum_nxt    = fnum_r;
    neg_nxt     = neg_r;
    started_nxt = started_r;
    digit_nxt   = digit_r;
    stop_nxt    = stop_r;
    fval_nxt    = fval_r;
    res_vld     = 1'b0;
    res_ctl.kind = kind_r;
    res_ctl.perr = perr_f;
    res_ctl.upd  = (kind_r == trlp_pkg::KIND_V) && !perr_f;
    res_ctl.stop = ((kind_r == trlp_pkg::KIND_DI) && !perr_f) ?
                   (fval_r[0] == VALUE_BITS'(1)) : stop_r;
    res_v0 = perr_f ? '0 : fval_r[0];
    res_v1 = perr_f ? '0 : fval_r[1];
    res_v2 = perr_f ? '0 : fval_r[2];

    if (go) begin
      if (phase_r == PH_HUNT) begin
        // Hunt for a trigger letter
        phase_nxt = PH_PREFIX;
        ppos_nxt  = 1'b0;
        unique case (rx_byte)
          trlp_pkg::CH_V:     kind_nxt = trlp_pkg::KIND_V;
          trlp_pkg::CH_T:     kind_nxt = trlp_pkg::KIND_T;
          trlp_pkg::CH_P:     kind_nxt = trlp_pkg::KIND_P;
          trlp_pkg::CH_B:     kind_nxt = trlp_pkg::KIND_BA;
          trlp_pkg::CH_A:     kind_nxt = trlp_pkg::KIND_A;
          trlp_pkg::CH_D:     kind_nxt = trlp_pkg::KIND_DI;
          trlp_pkg::CH_QUERY: begin
            kind_nxt  = trlp_pkg::KIND_ECHO;
            phase_nxt = PH_SKIP;
            ppos_nxt  = ppos_r;
          end
          default: begin
            phase_nxt = PH_HUNT;
            ppos_nxt  = ppos_r;
          end
        endcase
      end else if (rx_byte == trlp_pkg::CH_CR) begin
        // Close the line: emit unless echo, commit stop switch, clear
        res_vld     = (kind_r != trlp_pkg::KIND_ECHO);
        stop_nxt    = res_ctl.stop;
        phase_nxt   = PH_HUNT;
        kind_nxt    = trlp_pkg::KIND_V;
        ppos_nxt    = 1'b0;
        pbad_nxt    = 1'b0;
        fnum_nxt    = 2'd0;
        neg_nxt     = 1'b0;
        started_nxt = 1'b0;
        digit_nxt   = 1'b0;
        fval_nxt[0] = '0;
        fval_nxt[1] = '0;
        fval_nxt[2] = '0;
      end else begin
        unique case (phase_r)
          PH_PREFIX: begin
            if (rx_byte != exp_ch) begin
              pbad_nxt  = 1'b1;
              phase_nxt = PH_SKIP;
            end else if (exp_ch == trlp_pkg::CH_EQ) begin
              phase_nxt   = PH_FIELDS;
              fnum_nxt    = 2'd0;
              neg_nxt     = 1'b0;
              started_nxt = 1'b0;
              digit_nxt   = 1'b0;
            end else begin
              ppos_nxt = 1'b1;
            end
          end
          PH_FIELDS: begin
            if (is_digit) begin
              fval_nxt[fnum_r] = sat;
              started_nxt      = 1'b1;
              digit_nxt        = 1'b1;
            end else if (is_sign && !started_r) begin
              started_nxt = 1'b1;
              neg_nxt     = (rx_byte == trlp_pkg::CH_MINUS);
            end else if (is_blank && !started_r) begin
              phase_nxt = PH_FIELDS;
            end else if ((rx_byte == trlp_pkg::CH_COLON) && digit_r && more_fields) begin
              fnum_nxt    = fnum_r + 2'd1;
              neg_nxt     = 1'b0;
              started_nxt = 1'b0;
              digit_nxt   = 1'b0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_SKIP: phase_nxt = PH_SKIP;
          default: phase_nxt = PH_HUNT;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      kind_r    <= trlp_pkg::KIND_V;
      ppos_r    <= 1'b0;
      pbad_r    <= 1'b0;
      fnum_r    <= 2'd0;
      neg_r     <= 1'b0;
      started_r <= 1'b0;
      digit_r   <= 1'b0;
      stop_r    <= 1'b1;
      fval_r[0] <= '0;
      fval_r[1] <= '0;
      fval_r[2] <= '0;
    end else begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      ppos_r    <= ppos_nxt;
      pbad_r    <= pbad_nxt;
      fnum_r    <= fnum_nxt;
      neg_r     <= neg_nxt;
      started_r <= started_nxt;
      digit_r   <= digit_nxt;
      stop_r    <= stop_nxt;
      fval_r    <= fval_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/trlp_avg.sv */
`default_nettype none

module trlp_avg #(
  parameter int VALUE_BITS = 21
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               load,
  input  wire logic signed [VALUE_BITS-1:0]       v_second,
  input  wire logic                               commit,
  output logic [trlp_pkg::AVG_W-1:0]              avg_q,
  output logic [trlp_pkg::AVG_W-1:0]              avg_new
);

  localparam int UW = (VALUE_BITS - 1 > trlp_pkg::UV_CAP_W) ?
                      (VALUE_BITS - 1) : trlp_pkg::UV_CAP_W;
  localparam logic [UW-1:0] CAP = UW'(trlp_pkg::UV_CAP);

  logic [trlp_pkg::AVG_W-1:0]    avg_r;
  logic [trlp_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [UW-1:0]                 uv, uvc;
  logic [trlp_pkg::SUM_W-1:0]    avg_e, avg19;
  logic [trlp_pkg::DIV_X_W-1:0]  div_x;
  logic [trlp_pkg::PROD_W-1:0]   prod;
  logic [trlp_pkg::QUO_W-1:0]    quo;

  // Clamp the voltage at zero and at the point where the average saturates
  always_comb begin
    uv      = v_second[VALUE_BITS-1] ? '0 : UW'(v_second[VALUE_BITS-2:0]);
    uvc     = (uv > CAP) ? CAP : uv;
    avg_e   = trlp_pkg::SUM_W'(avg_r);
    avg19   = (avg_e << 4) + (avg_e << 1) + avg_e;
    sum_nxt = avg19 + (trlp_pkg::SUM_W'(uvc) << trlp_pkg::AVG_FRAC);
  end

  // Divide by twenty: drop two bits, then reciprocal multiply by one fifth
  always_comb begin
    div_x   = sum_r[trlp_pkg::SUM_W-1:2];
    prod    = trlp_pkg::PROD_W'(div_x) * trlp_pkg::PROD_W'(trlp_pkg::RECIP_5);
    quo     = prod[trlp_pkg::PROD_W-1:trlp_pkg::RECIP_SH];
    avg_new = (quo > trlp_pkg::QUO_W'(trlp_pkg::AVG_MAX)) ?
              trlp_pkg::AVG_MAX : quo[trlp_pkg::AVG_W-1:0];
  end

  assign avg_q = avg_r;

  // Hold the weighted sum for the next stage
  always_ff @(posedge clk) begin
    if (load) begin
      sum_r <= sum_nxt;
    end
  end

  // Update the running average when a good voltage line leaves the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
    end else if (commit) begin
      avg_r <= avg_new;
    end
  end

endmodule

`default_nettype wire

/* sv/telemetry_reply_line_parser.sv */
// Throughput: one input beat per cycle unless out_stall backs up the pipe; a good voltage
//   line that closely trails another good voltage line waits until the average commits.
// Pipeline: input register, parser, battery-sum register, output register.
// Reset: synchronous, active low; clears the parser to hunting, the average to zero and
//   sets the stop flag; no clearing pass.
`default_nettype none

module telemetry_reply_line_parser #(
  parameter int VALUE_BITS = 21
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_msg_kind,
  output logic                               out_prefix_error,
  output logic signed [VALUE_BITS-1:0]       out_value_first,
  output logic signed [VALUE_BITS-1:0]       out_value_second,
  output logic signed [VALUE_BITS-1:0]       out_value_third,
  output logic [trlp_pkg::AVG_W-1:0]         out_battery_avg_q8,
  output logic                               out_stop_flag
);

  logic                          v1_r, v2_r, v3_r, out_valid_r;
  logic [7:0]                    byte_r;
  trlp_pkg::line_ctl_t           ctl2_r, ctl3_r, par_ctl;
  logic signed [VALUE_BITS-1:0]  a2_r, b2_r, c2_r, a3_r, b3_r, c3_r;
  logic signed [VALUE_BITS-1:0]  par_v0, par_v1, par_v2;
  logic                          par_vld;
  logic                          o_free, s3_go, s3_free, s2_go, s2_free, s1_go, in_take;
  logic [trlp_pkg::AVG_W-1:0]    avg_q, avg_new;

  logic [2:0]                    kind_o_r;
  logic                          perr_o_r, stop_o_r;
  logic signed [VALUE_BITS-1:0]  a_o_r, b_o_r, c_o_r;
  logic [trlp_pkg::AVG_W-1:0]    avg_o_r;

  // Stage advance: a stage moves when the one ahead has room; voltage may await the average
  assign o_free  = !out_valid_r || !out_stall;
  assign s3_go   = v3_r && o_free;
  assign s3_free = !v3_r || s3_go;
  assign s2_go   = v2_r && s3_free && !(v3_r && ctl3_r.upd && ctl2_r.upd);
  assign s2_free = !v2_r || s2_go;
  assign s1_go   = v1_r && s2_free;
  assign in_stall = v1_r && !s2_free;
  assign in_take  = in_valid && !in_stall;

  trlp_parse #(.VALUE_BITS(VALUE_BITS)) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (s1_go),
    .rx_byte (byte_r),
    .res_vld (par_vld),
    .res_ctl (par_ctl),
    .res_v0  (par_v0),
    .res_v1  (par_v1),
    .res_v2  (par_v2)
  );

  trlp_avg #(.VALUE_BITS(VALUE_BITS)) u_avg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s2_go),
    .v_second (b2_r),
    .commit   (s3_go && ctl3_r.upd),
    .avg_q    (avg_q),
    .avg_new  (avg_new)
  );

  // Valid bits of the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        v1_r <= 1'b1;
      end else if (s1_go) begin
        v1_r <= 1'b0;
      end
      if (par_vld) begin
        v2_r <= 1'b1;
      end else if (s2_go) begin
        v2_r <= 1'b0;
      end
      if (s2_go) begin
        v3_r <= 1'b1;
      end else if (s3_go) begin
        v3_r <= 1'b0;
      end
      if (s3_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_rx_byte;
    end
    if (par_vld) begin
      ctl2_r <= par_ctl;
      a2_r   <= par_v0;
      b2_r   <= par_v1;
      c2_r   <= par_v2;
    end
    if (s2_go) begin
      ctl3_r <= ctl2_r;
      a3_r   <= a2_r;
      b3_r   <= b2_r;
      c3_r   <= c2_r;
    end
    if (s3_go) begin
      kind_o_r <= ctl3_r.kind;
      perr_o_r <= ctl3_r.perr;
      stop_o_r <= ctl3_r.stop;
      a_o_r    <= a3_r;
      b_o_r    <= b3_r;
      c_o_r    <= c3_r;
      avg_o_r  <= ctl3_r.upd ? avg_new : avg_q;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_msg_kind       = kind_o_r;
  assign out_prefix_error   = perr_o_r;
  assign out_value_first    = a_o_r;
  assign out_value_second   = b_o_r;
  assign out_value_third    = c_o_r;
  assign out_battery_avg_q8 = avg_o_r;
  assign out_stop_flag      = stop_o_r;

endmodule

`default_nettype wire

/* sv/trlp_checker.sv */
`default_nettype none

module trlp_checker #(
  parameter int VALUE_BITS = 21
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic [7:0]                   in_rx_byte,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [2:0]                   out_msg_kind,
  input wire logic                         out_prefix_error,
  input wire logic signed [VALUE_BITS-1:0] out_value_first,
  input wire logic signed [VALUE_BITS-1:0] out_value_second,
  input wire logic signed [VALUE_BITS-1:0] out_value_third,
  input wire logic [trlp_pkg::AVG_W-1:0]   out_battery_avg_q8,
  input wire logic                         out_stop_flag
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value_first) &&
    $stable(out_value_second) && $stable(out_battery_avg_q8))
    else $error("stalled result beat changed");

  // Echo lines never reach the output
  a_no_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_msg_kind != trlp_pkg::KIND_ECHO) && (out_msg_kind != 3'd7))
    else $error("echo or unknown kind emitted");

  // A bad prefix reports no field values
  a_perr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prefix_error |->
    (out_value_first == '0) && (out_value_second == '0) && (out_value_third == '0))
    else $error("prefix error with nonzero fields");

  // Only a voltage line carries a third field
  a_third_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_msg_kind != trlp_pkg::KIND_V) |-> (out_value_third == '0))
    else $error("third field on non-voltage line");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind telemetry_reply_line_parser trlp_checker #(.VALUE_BITS(VALUE_BITS)) u_trlp_checker (.*);

`default_nettype wire
